/* rtl/core/lcas_pkg.sv */
package lcas_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 11;
	localparam int COUNT_W     = 4;
	localparam int MIN_SIZE    = 3;
	localparam int RESET_SIZE  = 26;

	localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 2'd1;

	localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;
	localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;

	typedef struct packed {
		logic emit;
		logic last;
	} tag_t;

	typedef struct packed {
		logic               next_alive;
		logic [COUNT_W-1:0] neighbour_count;
		logic               last_cell;
	} result_t;

	function automatic int clamp_size(input int raw, input int maxv);
		int r;
		r = raw;
		if (raw < MIN_SIZE) begin
			r = MIN_SIZE;
		end else if (raw > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

	// window bit index = column * 3 + row; centre is bit 4
	function automatic logic [COUNT_W-1:0] count_neighbours(input logic [8:0] win);
		logic [COUNT_W-1:0] n;
		n = '0;
		for (int k = 0; k < 9; k++) begin
			if (k != 4) begin
				n = n + COUNT_W'(win[k]);
			end
		end
		return n;
	endfunction

	function automatic logic next_state(input logic centre, input logic [COUNT_W-1:0] n);
		logic alive;
		if (centre) begin
			alive = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
		end else begin
			alive = (n == BIRTH_COUNT);
		end
		return alive;
	endfunction

endpackage

/* rtl/core/lcas_cell_if.sv */
interface lcas_cell_if;
	logic valid;
	logic ready;
	logic cell_alive;

	modport source(output valid, output cell_alive, input ready);
	modport sink(input valid, input cell_alive, output ready);
endinterface

/* rtl/core/lcas_result_if.sv */
interface lcas_result_if;
	logic                        valid;
	logic                        ready;
	logic                        next_alive;
	logic [lcas_pkg::COUNT_W-1:0] neighbour_count;
	logic                        last_cell;

	modport source(output valid, output next_alive, output neighbour_count,
		output last_cell, input ready);
	modport sink(input valid, input next_alive, input neighbour_count,
		input last_cell, output ready);
endinterface

/* rtl/core/lcas_ctrl.sv */
module lcas_ctrl #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024,
	localparam int CW = $clog2(MAX_COLS),
	localparam int RW = $clog2(MAX_ROWS)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [lcas_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lcas_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             accept,
	output logic [CW-1:0]                    col,
	output lcas_pkg::tag_t                   tag,
	output logic                             restart
);

	logic [CW-1:0] cols_last_q;
	logic [RW-1:0] rows_last_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          cols_hit;
	logic          rows_hit;
	int            size_clamped;

	assign restart = cfg_write &&
		(cfg_index == lcas_pkg::REG_GRID_COLS || cfg_index == lcas_pkg::REG_GRID_ROWS);

	always_comb begin
		if (cfg_index == lcas_pkg::REG_GRID_COLS) begin
			size_clamped = lcas_pkg::clamp_size(int'(cfg_data), MAX_COLS);
		end else begin
			size_clamped = lcas_pkg::clamp_size(int'(cfg_data), MAX_ROWS);
		end
	end

	assign cols_hit = (col_q == cols_last_q);
	assign rows_hit = (row_q == rows_last_q);

	assign col      = col_q;
	assign tag.emit = (row_q >= RW'(2)) && (col_q >= CW'(2));
	assign tag.last = rows_hit && cols_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_last_q <= CW'(lcas_pkg::clamp_size(lcas_pkg::RESET_SIZE, MAX_COLS) - 1);
			rows_last_q <= RW'(lcas_pkg::clamp_size(lcas_pkg::RESET_SIZE, MAX_ROWS) - 1);
			col_q       <= '0;
			row_q       <= '0;
		end else if (restart) begin
			if (cfg_index == lcas_pkg::REG_GRID_COLS) begin
				cols_last_q <= CW'(size_clamped - 1);
			end else begin
				rows_last_q <= RW'(size_clamped - 1);
			end
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (cols_hit) begin
				col_q <= '0;
				row_q <= rows_hit ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

/* rtl/core/lcas_rowbuf.sv */
module lcas_rowbuf #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [1:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data
);

	// bit 1: row one above, bit 0: row two above
	logic [1:0] mem [DEPTH];
	logic [1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/lcas_eval.sv */
module lcas_eval #(
	parameter int CW = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              cell_alive,
	input  logic [CW-1:0]     col,
	input  lcas_pkg::tag_t    tag,
	input  logic              restart,
	input  logic [1:0]        rd_data,
	output logic              wr_en,
	output logic [CW-1:0]     wr_addr,
	output logic [1:0]        wr_data,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	output lcas_pkg::result_t result
);

	logic              valid_s1;
	logic              cell_s1;
	logic [CW-1:0]     col_s1;
	lcas_pkg::tag_t    tag_s1;
	logic [8:0]        window_q;
	logic [8:0]        window_next;
	logic              advance;
	logic              out_valid_q;
	lcas_pkg::result_t result_q;
	lcas_pkg::result_t result_next;

	assign advance  = valid_s1 && (!tag_s1.emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign window_next = {cell_s1, rd_data[1], rd_data[0], window_q[8:3]};

	assign result_next.neighbour_count = lcas_pkg::count_neighbours(window_next);
	assign result_next.next_alive      =
		lcas_pkg::next_state(window_next[4], result_next.neighbour_count);
	assign result_next.last_cell       = tag_s1.last;

	// shift the row stores down by one row at this column
	assign wr_en   = advance;
	assign wr_addr = col_s1;
	assign wr_data = {cell_s1, rd_data[1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= cell_alive;
			col_s1  <= col;
			tag_s1  <= tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (restart) begin
			window_q <= '0;
		end else if (advance) begin
			window_q <= window_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && tag_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tag_s1.emit) begin
			result_q <= result_next;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

/* rtl/core/life_cellular_automaton_step_unit.sv */
// One generation of the B3/S23 life rule over a raster cell stream.
// cells: one cell bit per request, padded grid row by row, halo included.
// results: one request per interior cell once its 3x3 window is complete,
//   carrying the next state, the eight-neighbour count and a flag on the
//   last interior cell of the generation.
// cfg: write grid_cols (index 0) or grid_rows (index 1); sizes clamp to
//   3..MAX_COLS / 3..MAX_ROWS, and each write to either restarts the generation.
//   Write only while no request is in flight.
// Path: the cell that completes a window waits in the input register, and
//   its result is then loaded into the result register.
// Throughput: one cell per cycle while no stall holds the input register; the
//   row-store memory is read when a cell is taken and written when that cell
//   leaves the input register, so its single read and write ports keep pace.
// Reset clears positions, window and valid flags; sizes return to 26.
//   Row stores are not cleared; stale entries reach only windows not emitted.
// Stall: while a result waits, cells keep flowing through the input
//   register until one that completes a window reaches it; hold that one
//   and the input until the result is taken.
module life_cellular_automaton_step_unit #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	lcas_cell_if.sink                        cells,
	lcas_result_if.source                    results,
	input  logic                             cfg_write,
	input  logic [lcas_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lcas_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = $clog2(MAX_COLS);

	logic              accept;
	logic              in_ready;
	logic              restart;
	logic [CW-1:0]     col;
	lcas_pkg::tag_t    tag;
	logic [1:0]        rd_data;
	logic              wr_en;
	logic [CW-1:0]     wr_addr;
	logic [1:0]        wr_data;
	lcas_pkg::result_t result;

	assign cells.ready = in_ready;
	assign accept      = cells.valid && in_ready;

	lcas_ctrl #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.col      (col),
		.tag      (tag),
		.restart  (restart)
	);

	lcas_rowbuf #(
		.DEPTH(MAX_COLS)
	) u_rowbuf (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(col),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	lcas_eval #(
		.CW(CW)
	) u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cell_alive(cells.cell_alive),
		.col       (col),
		.tag       (tag),
		.restart   (restart),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.in_ready  (in_ready),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.result    (result)
	);

	assign results.next_alive      = result.next_alive;
	assign results.neighbour_count = result.neighbour_count;
	assign results.last_cell       = result.last_cell;

endmodule

/* rtl/core/lcas_checker.sv */
module lcas_checker (
	input logic           clk,
	input logic           arst_n,
	lcas_cell_if.sink     cells,
	lcas_result_if.source results
);

	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=> results.valid)
		else $error("result request dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=> $stable(results.next_alive) &&
			$stable(results.neighbour_count) && $stable(results.last_cell))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(cells.valid && cells.ready, 2))
		else $error("result without a cell taken two cycles before");

	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.neighbour_count <= 4'd8) &&
			(!results.next_alive || results.neighbour_count == 4'd2 ||
			results.neighbour_count == 4'd3))
		else $error("next state inconsistent with neighbour count");

endmodule

bind life_cellular_automaton_step_unit lcas_checker u_lcas_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.cells  (cells),
	.results(results)
);
